[hw/rtl/stli_pkg.sv]
// Shared types, codes and constants of the sorted table interpolator.
`timescale 1ns / 1ps
package stli_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [31:0] LOG2_10_Q30 = 32'd3566893132;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic signed [63:0] POW_LIM = 64'sd42949672960;
	localparam logic [63:0] SAT_VALUE = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [3:0] TAYLOR_LAST = 4'd13;
	localparam logic [5:0] INTERP_STEPS = 6'd32;
	localparam logic [5:0] TERM_STEPS = 6'd34;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic CFG_CLAMP = 1'b0;
	localparam logic CFG_LOG = 1'b1;

	typedef enum logic [2:0] {
		ST_DONE = 3'd0,
		ST_CLAMPED = 3'd1,
		ST_ZEROED = 3'd2,
		ST_FEW = 3'd3,
		ST_REJECT = 3'd4,
		ST_SAT = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		RD_MID, RD_ZERO, RD_LAST, RD_JM1, RD_I, RD_I1
	} rd_sel_t;

	typedef enum logic [2:0] {
		RS_NONE, RS_ZERO, RS_V, RS_SAT, RS_POW
	} res_sel_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_SRCH, S_SRCH_CMP, S_SHIFT, S_SHIFT_WR, S_INSERT,
		S_Q_CK0, S_Q_CKL, S_Q_RDI, S_Q_LAT1, S_DIV_ST, S_DIV, S_MUL_HI, S_MUL_LO,
		S_SUM, S_POST, S_P_W, S_P_Y, S_T_MUL, S_T_DS, S_T_DIV, S_P_OUT, S_EMIT
	} state_t;

	typedef struct packed {
		logic latch;
		logic clr_cnt;
		logic srch_init;
		logic srch_step;
		logic shift_init;
		logic shift_wr;
		logic insert;
		logic set_end;
		logic lat0;
		logic lat1;
		logic div_interp;
		logic div_term;
		logic mul_hi;
		logic mul_lo;
		logic interp_sum;
		logic pow_mag;
		logic pow_w;
		logic pow_y;
		logic term_mul;
		logic term_upd;
		logic emit;
		rd_sel_t rd_sel;
		res_sel_t res_sel;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic cnt_full;
		logic cnt_few;
		logic srch_more;
		logic dup;
		logic j_gt_p;
		logic x_le_rd;
		logic x_ge_rd;
		logic outside;
		logic v_ge_lim;
		logic v_le_lim;
		logic div_busy;
		logic k_last;
		logic n_sat;
		logic out_full;
	} sts_t;

endpackage

[hw/rtl/stli_if.sv]
// Input and result channel interfaces of the interpolator.
`timescale 1ns / 1ps
interface stli_in_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	modport source (output valid, operation, x_value, y_value, input ready);
	modport sink (input valid, operation, x_value, y_value, output ready);
endinterface

interface stli_out_if;
	logic valid;
	logic ready;
	logic signed [63:0] result_value;
	logic [2:0] status;
	logic [8:0] points_held;
	modport source (output valid, result_value, status, points_held, input ready);
	modport sink (input valid, result_value, status, points_held, output ready);
endinterface

[hw/rtl/sorted_table_linear_interpolator.sv]
// Top level of the sorted table linear interpolator.
// Usage: items arrive on in_ch (operation, x_value, y_value), one result
// beat per item leaves on out_ch (result_value, status, points_held).
// Items are processed one at a time; the next item is taken as soon as
// the previous result sits in the output register, even if out_ch stalls.
// Work per item: a clear resets the count; a load runs a binary search
// over the n points for insert position p, then moves the n-p entries above p
// up one at a time through the single store write port and inserts.
// A query runs the search, then a 32-step serial divide for the segment
// fraction and two multiplies. Log mode adds thirteen Taylor terms, each
// with a 34-step serial divide by the term index on the shared divider.
// Reset empties the table, sets clamping on and log mode off; the stores
// need no clearing. cfg_we writes register cfg_index (0 clamp, 1 log mode)
// from cfg_data; write only while idle. A stalled out_ch holds its beat
// and stops the block once a second result is ready.
`timescale 1ns / 1ps
module sorted_table_linear_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	stli_in_if.sink     in_ch,
	stli_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data
);
	logic clamp_q, log_q;
	stli_pkg::cmd_t cmd;
	stli_pkg::sts_t sts;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= 1'b1;
			log_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == stli_pkg::CFG_CLAMP) clamp_q <= cfg_data;
			if (cfg_index == stli_pkg::CFG_LOG) log_q <= cfg_data;
		end
	end

	stli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.clamp    (clamp_q),
		.log_mode (log_q),
		.sts      (sts),
		.cmd      (cmd)
	);

	stli_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (in_ch.operation),
		.in_x       (in_ch.x_value),
		.in_y       (in_ch.y_value),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_result (out_ch.result_value),
		.out_status (out_ch.status),
		.out_points (out_ch.points_held)
	);

	// One item at a time: an accepted beat closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input accepted while an item is in work");

	a_points: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.points_held <= 9'(stli_pkg::TABLE_DEPTH)))
		else $error("point count beyond table depth");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.status <= 3'(stli_pkg::ST_SAT)))
		else $error("status code out of range");
endmodule

[hw/rtl/stli_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module stli_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] rem_init,
	input  logic [33:0] dividend,
	input  logic [32:0] divisor,
	input  logic [5:0]  steps,
	output logic        busy,
	output logic [33:0] quotient
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [33:0] dvd_q;
	logic [32:0] dvs_q;
	logic [33:0] quo_q;
	logic [33:0] trial;
	logic        fits;

	// Shift in the next dividend bit and test against the divisor
	assign trial = {rem_q, dvd_q[33]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			busy_q <= cnt_q != 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 33'(trial - {1'b0, dvs_q}) : trial[32:0];
			dvd_q <= {dvd_q[32:0], 1'b0};
			quo_q <= {quo_q[32:0], fits};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;
endmodule

[hw/rtl/stli_ctrl.sv]
// Sequencer of the interpolator: issues datapath commands per item.
`timescale 1ns / 1ps
module stli_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           clamp,
	input  logic           log_mode,
	input  stli_pkg::sts_t sts,
	output stli_pkg::cmd_t cmd
);
	stli_pkg::state_t state_q, state_d;
	stli_pkg::status_t base_st;

	assign base_st = sts.outside ? stli_pkg::ST_CLAMPED : stli_pkg::ST_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= stli_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stli_pkg::S_IDLE: if (in_valid) state_d = stli_pkg::S_DISPATCH;
			stli_pkg::S_DISPATCH: begin
				case (sts.op)
					stli_pkg::OP_LOAD:
						state_d = sts.cnt_full ? stli_pkg::S_EMIT : stli_pkg::S_SRCH;
					stli_pkg::OP_QUERY:
						state_d = sts.cnt_few ? stli_pkg::S_EMIT : stli_pkg::S_Q_CK0;
					default: state_d = stli_pkg::S_EMIT;
				endcase
			end
			stli_pkg::S_SRCH: begin
				priority if (sts.srch_more) state_d = stli_pkg::S_SRCH_CMP;
				else if (sts.op == stli_pkg::OP_LOAD)
					state_d = sts.dup ? stli_pkg::S_EMIT : stli_pkg::S_SHIFT;
				else state_d = stli_pkg::S_Q_RDI;
			end
			stli_pkg::S_SRCH_CMP: state_d = stli_pkg::S_SRCH;
			stli_pkg::S_SHIFT:
				state_d = sts.j_gt_p ? stli_pkg::S_SHIFT_WR : stli_pkg::S_INSERT;
			stli_pkg::S_SHIFT_WR: state_d = stli_pkg::S_SHIFT;
			stli_pkg::S_INSERT: state_d = stli_pkg::S_EMIT;
			stli_pkg::S_Q_CK0:
				state_d = sts.x_le_rd ? stli_pkg::S_POST : stli_pkg::S_Q_CKL;
			stli_pkg::S_Q_CKL:
				state_d = sts.x_ge_rd ? stli_pkg::S_POST : stli_pkg::S_SRCH;
			stli_pkg::S_Q_RDI: state_d = stli_pkg::S_Q_LAT1;
			stli_pkg::S_Q_LAT1: state_d = stli_pkg::S_DIV_ST;
			stli_pkg::S_DIV_ST: state_d = stli_pkg::S_DIV;
			stli_pkg::S_DIV: if (!sts.div_busy) state_d = stli_pkg::S_MUL_HI;
			stli_pkg::S_MUL_HI: state_d = stli_pkg::S_MUL_LO;
			stli_pkg::S_MUL_LO: state_d = stli_pkg::S_SUM;
			stli_pkg::S_SUM: state_d = stli_pkg::S_POST;
			stli_pkg::S_POST: begin
				priority if ((sts.outside && !clamp) || !log_mode) state_d = stli_pkg::S_EMIT;
				else if (sts.v_ge_lim || sts.v_le_lim) state_d = stli_pkg::S_EMIT;
				else state_d = stli_pkg::S_P_W;
			end
			stli_pkg::S_P_W: state_d = stli_pkg::S_P_Y;
			stli_pkg::S_P_Y: state_d = stli_pkg::S_T_MUL;
			stli_pkg::S_T_MUL: state_d = stli_pkg::S_T_DS;
			stli_pkg::S_T_DS: state_d = stli_pkg::S_T_DIV;
			stli_pkg::S_T_DIV: begin
				if (!sts.div_busy)
					state_d = sts.k_last ? stli_pkg::S_P_OUT : stli_pkg::S_T_MUL;
			end
			stli_pkg::S_P_OUT: state_d = stli_pkg::S_EMIT;
			stli_pkg::S_EMIT: if (!sts.out_full) state_d = stli_pkg::S_IDLE;
			default: state_d = stli_pkg::S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		cmd.rd_sel = stli_pkg::RD_MID;
		cmd.res_sel = stli_pkg::RS_NONE;
		cmd.res_status = stli_pkg::ST_DONE;
		in_ready = 1'b0;
		unique case (state_q)
			stli_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.latch = in_valid;
			end
			stli_pkg::S_DISPATCH: begin
				case (sts.op)
					stli_pkg::OP_CLEAR: begin
						cmd.clr_cnt = 1'b1;
						cmd.res_sel = stli_pkg::RS_ZERO;
					end
					stli_pkg::OP_LOAD: begin
						if (sts.cnt_full) begin
							cmd.res_sel = stli_pkg::RS_ZERO;
							cmd.res_status = stli_pkg::ST_REJECT;
						end else cmd.srch_init = 1'b1;
					end
					stli_pkg::OP_QUERY: begin
						if (sts.cnt_few) begin
							cmd.res_sel = stli_pkg::RS_ZERO;
							cmd.res_status = stli_pkg::ST_FEW;
						end else cmd.rd_sel = stli_pkg::RD_ZERO;
					end
					default: cmd.res_sel = stli_pkg::RS_ZERO;
				endcase
			end
			stli_pkg::S_SRCH: begin
				priority if (sts.srch_more) cmd.rd_sel = stli_pkg::RD_MID;
				else if (sts.op == stli_pkg::OP_LOAD) begin
					if (sts.dup) begin
						cmd.res_sel = stli_pkg::RS_ZERO;
						cmd.res_status = stli_pkg::ST_REJECT;
					end else cmd.shift_init = 1'b1;
				end else cmd.rd_sel = stli_pkg::RD_I;
			end
			stli_pkg::S_SRCH_CMP: cmd.srch_step = 1'b1;
			stli_pkg::S_SHIFT: cmd.rd_sel = stli_pkg::RD_JM1;
			stli_pkg::S_SHIFT_WR: cmd.shift_wr = 1'b1;
			stli_pkg::S_INSERT: begin
				cmd.insert = 1'b1;
				cmd.res_sel = stli_pkg::RS_ZERO;
			end
			stli_pkg::S_Q_CK0: begin
				if (sts.x_le_rd) cmd.set_end = 1'b1;
				else cmd.rd_sel = stli_pkg::RD_LAST;
			end
			stli_pkg::S_Q_CKL: begin
				if (sts.x_ge_rd) cmd.set_end = 1'b1;
				else cmd.srch_init = 1'b1;
			end
			stli_pkg::S_Q_RDI: begin
				cmd.lat0 = 1'b1;
				cmd.rd_sel = stli_pkg::RD_I1;
			end
			stli_pkg::S_Q_LAT1: cmd.lat1 = 1'b1;
			stli_pkg::S_DIV_ST: cmd.div_interp = 1'b1;
			stli_pkg::S_DIV: ;
			stli_pkg::S_MUL_HI: cmd.mul_hi = 1'b1;
			stli_pkg::S_MUL_LO: cmd.mul_lo = 1'b1;
			stli_pkg::S_SUM: cmd.interp_sum = 1'b1;
			stli_pkg::S_POST: begin
				priority if (sts.outside && !clamp) begin
					cmd.res_sel = stli_pkg::RS_ZERO;
					cmd.res_status = stli_pkg::ST_ZEROED;
				end else if (!log_mode) begin
					cmd.res_sel = stli_pkg::RS_V;
					cmd.res_status = base_st;
				end else if (sts.v_ge_lim) begin
					cmd.res_sel = stli_pkg::RS_SAT;
					cmd.res_status = stli_pkg::ST_SAT;
				end else if (sts.v_le_lim) begin
					cmd.res_sel = stli_pkg::RS_ZERO;
					cmd.res_status = base_st;
				end else cmd.pow_mag = 1'b1;
			end
			stli_pkg::S_P_W: cmd.pow_w = 1'b1;
			stli_pkg::S_P_Y: cmd.pow_y = 1'b1;
			stli_pkg::S_T_MUL: cmd.term_mul = 1'b1;
			stli_pkg::S_T_DS: cmd.div_term = 1'b1;
			stli_pkg::S_T_DIV: cmd.term_upd = !sts.div_busy;
			stli_pkg::S_P_OUT: begin
				if (sts.n_sat) begin
					cmd.res_sel = stli_pkg::RS_SAT;
					cmd.res_status = stli_pkg::ST_SAT;
				end else begin
					cmd.res_sel = stli_pkg::RS_POW;
					cmd.res_status = base_st;
				end
			end
			stli_pkg::S_EMIT: cmd.emit = !sts.out_full;
			default: ;
		endcase
	end
endmodule

[hw/rtl/stli_dp.sv]
// Datapath: point stores, search window, interpolation and power of ten.
`timescale 1ns / 1ps
module stli_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stli_pkg::cmd_t         cmd,
	output stli_pkg::sts_t         sts,
	input  logic [1:0]             in_op,
	input  logic signed [31:0]     in_x,
	input  logic signed [31:0]     in_y,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [63:0]     out_result,
	output logic [2:0]             out_status,
	output logic [8:0]             out_points
);
	localparam int IW = stli_pkg::IDX_W;
	localparam int CW = stli_pkg::CNT_W;

	logic signed [31:0] x_mem [stli_pkg::TABLE_DEPTH];
	logic signed [31:0] y_mem [stli_pkg::TABLE_DEPTH];
	logic signed [31:0] rd_x_q, rd_y_q;
	logic [IW-1:0] rd_addr, wr_addr;
	logic wr_en;
	logic signed [31:0] wr_x, wr_y;

	logic [1:0] op_q;
	logic signed [31:0] x_q, y_q;
	logic [CW-1:0] cnt_q, lo_q, hi_q, j_q, mid_sum;
	logic [IW-1:0] mid;
	logic dup_q, outside_q;
	logic signed [31:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [63:0] v_q;

	logic signed [32:0] dx, tx, dy;
	logic [32:0] ady;
	logic [48:0] p1_q, p2_q;
	logic [49:0] off;
	logic signed [63:0] base;

	logic [63:0] mag;
	logic neg_q;
	logic [3:0] mag_hi_q;
	logic [63:0] prod_q;
	logic [37:0] wm;
	logic signed [6:0] n_q;
	logic [31:0] f_q, yq_q;
	logic [63:0] fprod;
	logic [32:0] term_q;
	logic [33:0] sum_q, a_q;
	logic [64:0] tprod;
	logic [3:0] k_q;
	logic [63:0] pow_val;
	logic [6:0] n_neg;

	logic div_start, div_busy;
	logic [32:0] div_rem0, div_dvs;
	logic [33:0] div_dvd, div_q;
	logic [5:0] div_steps;

	logic signed [63:0] res_w_q;
	logic [2:0] st_w_q;
	logic out_valid_q;
	logic signed [63:0] out_res_q;
	logic [2:0] out_st_q;
	logic [8:0] out_pts_q;

	// Search midpoint and read address
	assign mid_sum = CW'((CW + 1)'(lo_q) + (CW + 1)'(hi_q) >> 1);
	assign mid = mid_sum[IW-1:0];

	always_comb begin
		unique case (cmd.rd_sel)
			stli_pkg::RD_MID: rd_addr = mid;
			stli_pkg::RD_ZERO: rd_addr = '0;
			stli_pkg::RD_LAST: rd_addr = IW'(cnt_q - CW'(1));
			stli_pkg::RD_JM1: rd_addr = IW'(j_q - CW'(1));
			stli_pkg::RD_I: rd_addr = IW'(lo_q - CW'(1));
			stli_pkg::RD_I1: rd_addr = lo_q[IW-1:0];
			default: rd_addr = '0;
		endcase
	end

	// Store write: shift up one entry, or insert the new point
	always_comb begin
		wr_en = cmd.shift_wr | cmd.insert;
		wr_addr = cmd.insert ? lo_q[IW-1:0] : j_q[IW-1:0];
		wr_x = cmd.insert ? x_q : rd_x_q;
		wr_y = cmd.insert ? y_q : rd_y_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_mem[wr_addr] <= wr_x;
			y_mem[wr_addr] <= wr_y;
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.clr_cnt) cnt_q <= '0;
		else if (cmd.insert) cnt_q <= cnt_q + CW'(1);
	end

	// Item capture, search window and shift pointer
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= in_op;
			x_q <= in_x;
			y_q <= in_y;
		end
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= cnt_q;
			dup_q <= 1'b0;
		end else if (cmd.srch_step) begin
			if (op_q == stli_pkg::OP_LOAD) begin
				if (rd_x_q < x_q) lo_q <= mid_sum + CW'(1);
				else hi_q <= mid_sum;
				if (rd_x_q == x_q) dup_q <= 1'b1;
			end else begin
				if (rd_x_q > x_q) hi_q <= mid_sum;
				else lo_q <= mid_sum + CW'(1);
			end
		end
		if (cmd.shift_init) j_q <= cnt_q;
		else if (cmd.shift_wr) j_q <= j_q - CW'(1);
	end

	// Segment interpolation
	assign dx = 33'(x1_q) - 33'(x0_q);
	assign tx = 33'(x_q) - 33'(x0_q);
	assign dy = 33'(y1_q) - 33'(y0_q);
	assign ady = dy[32] ? 33'(-dy) : 33'(dy);
	assign off = 50'(p1_q) + 50'(p2_q >> 16);
	assign base = 64'(y0_q) <<< 16;

	always_ff @(posedge clk) begin
		if (cmd.lat0) begin
			x0_q <= rd_x_q;
			y0_q <= rd_y_q;
		end
		if (cmd.lat1) begin
			x1_q <= rd_x_q;
			y1_q <= rd_y_q;
		end
		if (cmd.mul_hi) p1_q <= 49'(ady) * 49'(div_q[31:16]);
		if (cmd.mul_lo) p2_q <= 49'(ady) * 49'(div_q[15:0]);
		if (cmd.set_end) begin
			v_q <= 64'(rd_y_q) <<< 16;
			outside_q <= 1'b1;
		end else if (cmd.interp_sum) begin
			v_q <= dy[32] ? base - 64'(off) : base + 64'(off);
			outside_q <= 1'b0;
		end
	end

	// Power of ten: scale by log2(10), split, Taylor series of 2^f
	assign mag = v_q[63] ? 64'(-v_q) : 64'(v_q);
	assign wm = 38'(({34'd0, mag_hi_q} * {6'd0, stli_pkg::LOG2_10_Q30}) << 2)
		+ 38'(prod_q >> 30);
	assign fprod = f_q * stli_pkg::LN2_Q32;
	assign tprod = term_q * yq_q;
	assign n_neg = 7'(-n_q);
	assign pow_val = n_q[6] ? 64'({30'd0, sum_q} >> n_neg[5:0])
		: 64'({30'd0, sum_q} << n_q[4:0]);

	always_ff @(posedge clk) begin
		if (cmd.pow_mag) begin
			neg_q <= v_q[63];
			mag_hi_q <= mag[35:32];
			prod_q <= mag[31:0] * stli_pkg::LOG2_10_Q30;
		end
		if (cmd.pow_w) begin
			if (!neg_q) begin
				n_q <= 7'({1'b0, wm[37:32]});
				f_q <= wm[31:0];
			end else if (wm[31:0] == 32'd0) begin
				n_q <= 7'(-{1'b0, wm[37:32]});
				f_q <= '0;
			end else begin
				n_q <= 7'(-{1'b0, wm[37:32]} - 7'd1);
				f_q <= 32'(33'h1_0000_0000 - {1'b0, wm[31:0]});
			end
		end
		if (cmd.pow_y) begin
			yq_q <= fprod[63:32];
			term_q <= 33'h1_0000_0000;
			sum_q <= 34'h1_0000_0000;
			k_q <= 4'd1;
		end
		if (cmd.term_mul) a_q <= 34'(tprod >> 32);
		if (cmd.term_upd) begin
			term_q <= div_q[32:0];
			sum_q <= sum_q + div_q;
			k_q <= k_q + 4'd1;
		end
	end

	// Shared divider: segment fraction and Taylor terms
	assign div_start = cmd.div_interp | cmd.div_term;
	assign div_rem0 = cmd.div_interp ? 33'(tx) : 33'd0;
	assign div_dvd = cmd.div_interp ? 34'd0 : a_q;
	assign div_dvs = cmd.div_interp ? 33'(dx) : 33'(k_q);
	assign div_steps = cmd.div_interp ? stli_pkg::INTERP_STEPS : stli_pkg::TERM_STEPS;

	stli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem0),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.steps    (div_steps),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// Stage the result, then hand it to the output register
	always_ff @(posedge clk) begin
		unique case (cmd.res_sel)
			stli_pkg::RS_NONE: ;
			stli_pkg::RS_ZERO: res_w_q <= '0;
			stli_pkg::RS_V: res_w_q <= v_q;
			stli_pkg::RS_SAT: res_w_q <= stli_pkg::SAT_VALUE;
			stli_pkg::RS_POW: res_w_q <= pow_val;
			default: ;
		endcase
		if (cmd.res_sel != stli_pkg::RS_NONE) st_w_q <= cmd.res_status;
		if (cmd.emit) begin
			out_res_q <= res_w_q;
			out_st_q <= st_w_q;
			out_pts_q <= 9'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_result = out_res_q;
	assign out_status = out_st_q;
	assign out_points = out_pts_q;

	// Status back to the sequencer
	always_comb begin
		sts.op = op_q;
		sts.cnt_full = cnt_q >= CW'(stli_pkg::TABLE_DEPTH);
		sts.cnt_few = cnt_q < CW'(2);
		sts.srch_more = lo_q < hi_q;
		sts.dup = dup_q;
		sts.j_gt_p = j_q > lo_q;
		sts.x_le_rd = x_q <= rd_x_q;
		sts.x_ge_rd = x_q >= rd_x_q;
		sts.outside = outside_q;
		sts.v_ge_lim = v_q >= stli_pkg::POW_LIM;
		sts.v_le_lim = v_q <= -stli_pkg::POW_LIM;
		sts.div_busy = div_busy;
		sts.k_last = k_q == stli_pkg::TAYLOR_LAST;
		sts.n_sat = !n_q[6] && (n_q >= 7'sd31);
		sts.out_full = out_valid_q && !out_ready;
	end
endmodule

[sim/tb_sorted_table_linear_interpolator.sv]
// Testbench of the sorted table linear interpolator: table loads, queries and modes.
`timescale 1ns / 1ps
module tb_sorted_table_linear_interpolator;

	localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic signed [63:0] value;
		stli_pkg::status_t status;
		logic [8:0] held;
	} interp_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic cfg_data = 1'b0;

	stli_in_if in_ch ();
	stli_out_if out_ch ();

	sorted_table_linear_interpolator dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Predictor state: sorted table and register copies
	logic signed [31:0] tbl_x [stli_pkg::TABLE_DEPTH];
	logic signed [31:0] tbl_y [stli_pkg::TABLE_DEPTH];
	int unsigned tbl_count = 0;
	logic clamp_on = 1'b1;
	logic log_on = 1'b0;

	interp_result_t pending_results [$];
	int error_count = 0;
	int cycle_count = 0;
	int stall_mode = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.operation = stli_pkg::OP_CLEAR;
		in_ch.x_value = '0;
		in_ch.y_value = '0;
		out_ch.ready = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// 10^v on a Q32.32 value
	function automatic logic signed [63:0] power_of_ten(input logic signed [63:0] v,
			output logic sat);
		logic neg;
		logic [63:0] mag, wm, f, y, term, sum;
		longint n;
		sat = 1'b0;
		if (v >= stli_pkg::POW_LIM) begin
			sat = 1'b1;
			return stli_pkg::SAT_VALUE;
		end
		if (v <= -stli_pkg::POW_LIM) return 0;
		neg = v < 0;
		mag = neg ? -v : v;
		wm = (mag >> 32) * {32'd0, stli_pkg::LOG2_10_Q30} * 4
			+ (((mag & 64'hFFFF_FFFF) * {32'd0, stli_pkg::LOG2_10_Q30}) >> 30);
		if (!neg) begin
			n = longint'(wm >> 32);
			f = wm & 64'hFFFF_FFFF;
		end else if ((wm & 64'hFFFF_FFFF) == 0) begin
			n = -longint'(wm >> 32);
			f = 0;
		end else begin
			n = -longint'(wm >> 32) - 1;
			f = ONE_Q32 - (wm & 64'hFFFF_FFFF);
		end
		y = (f * {32'd0, stli_pkg::LN2_Q32}) >> 32;
		term = ONE_Q32;
		sum = ONE_Q32;
		for (int k = 1; k <= 13; k++) begin
			term = ((term * y) >> 32) / k;
			sum += term;
		end
		if (n >= 31) begin
			sat = 1'b1;
			return stli_pkg::SAT_VALUE;
		end
		if (n >= 0) return sum << n;
		if (-n >= 64) return 0;
		return sum >> (-n);
	endfunction

	function automatic logic signed [63:0] segment_value(input logic signed [63:0] x,
			input int i);
		logic signed [63:0] x0, x1, y0, y1, dy, base;
		logic [63:0] dx, t, frac, ady, off;
		x0 = tbl_x[i];
		x1 = tbl_x[i + 1];
		y0 = tbl_y[i];
		y1 = tbl_y[i + 1];
		dx = x1 - x0;
		t = x - x0;
		frac = (t << 32) / dx;
		dy = y1 - y0;
		ady = dy < 0 ? -dy : dy;
		off = ady * (frac >> 16) + ((ady * (frac & 64'hFFFF)) >> 16);
		base = y0 * 65536;
		return dy < 0 ? base - off : base + off;
	endfunction

	// Predict one item's result and update the table copy
	function automatic interp_result_t predict_item(input logic [1:0] op,
			input logic signed [31:0] xv, input logic signed [31:0] yv);
		interp_result_t r;
		int p, i, last;
		logic outside, sat;
		logic signed [63:0] v;
		r.value = 0;
		r.status = stli_pkg::ST_DONE;
		if (op == stli_pkg::OP_CLEAR) begin
			tbl_count = 0;
		end else if (op == stli_pkg::OP_LOAD) begin
			p = 0;
			while (p < tbl_count && tbl_x[p] < xv) p++;
			if (tbl_count >= stli_pkg::TABLE_DEPTH || (p < tbl_count && tbl_x[p] == xv))
			begin
				r.status = stli_pkg::ST_REJECT;
			end else begin
				for (int j = tbl_count; j > p; j--) begin
					tbl_x[j] = tbl_x[j - 1];
					tbl_y[j] = tbl_y[j - 1];
				end
				tbl_x[p] = xv;
				tbl_y[p] = yv;
				tbl_count++;
			end
		end else if (op == stli_pkg::OP_QUERY) begin
			if (tbl_count < 2) begin
				r.status = stli_pkg::ST_FEW;
			end else begin
				last = tbl_count - 1;
				outside = 1'b1;
				if (xv <= tbl_x[0]) begin
					v = 64'(tbl_y[0]) * 65536;
				end else if (xv >= tbl_x[last]) begin
					v = 64'(tbl_y[last]) * 65536;
				end else begin
					i = 0;
					while (i + 1 < last && tbl_x[i + 1] <= xv) i++;
					v = segment_value(64'(xv), i);
					outside = 1'b0;
				end
				if (outside && !clamp_on) begin
					r.status = stli_pkg::ST_ZEROED;
				end else begin
					r.status = outside ? stli_pkg::ST_CLAMPED : stli_pkg::ST_DONE;
					if (log_on) begin
						v = power_of_ten(v, sat);
						if (sat) r.status = stli_pkg::ST_SAT;
					end
					r.value = v;
				end
			end
		end
		r.held = 9'(tbl_count);
		return r;
	endfunction

	// Send one beat and queue its expected result
	task automatic send_item(input logic [1:0] op, input logic signed [31:0] xv,
			input logic signed [31:0] yv);
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.x_value <= xv;
		in_ch.y_value <= yv;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_results.push_back(predict_item(op, xv, yv));
		// hold valid through bursts, drop it for a random gap
		if ($urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_and_settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Write one register, then wait with cfg_we low so that writes stay apart
	task automatic write_register(input logic idx, input logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == stli_pkg::CFG_CLAMP) clamp_on = val;
		else log_on = val;
		@(posedge clk);
	endtask

	// Receiver stall pattern
	always @(posedge clk) begin
		cycle_count++;
		case (stall_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= ($urandom_range(0, 2) != 0);
			default: out_ch.ready <= (cycle_count % 7) < 3;
		endcase
		if (cycle_count % 500 == 0) stall_mode <= $urandom_range(0, 2);
	end

	// Result checker
	always @(posedge clk) begin
		interp_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", out_ch.result_value, 0);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.result_value !== want.value)
					report_mismatch("result_value", out_ch.result_value, want.value);
				if (out_ch.status !== want.status)
					report_mismatch("status", out_ch.status, want.status);
				if (out_ch.points_held !== want.held)
					report_mismatch("points_held", out_ch.points_held, want.held);
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_sorted_table_linear_interpolator NOT OK");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(stli_pkg::OP_QUERY, 0, 0);
		send_item(stli_pkg::OP_LOAD, 32'sh0001_0000, 32'sh0002_0000);
		send_item(stli_pkg::OP_QUERY, 0, 0);
		send_item(stli_pkg::OP_LOAD, 32'sh0001_0000, 5);
		send_item(stli_pkg::OP_LOAD, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_item(stli_pkg::OP_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_item(stli_pkg::OP_LOAD, 32'sh0003_8000, -32'sh0001_4000);
		send_item(stli_pkg::OP_QUERY, 32'sh8000_0000, 32'shFFFF_FFFF);
		send_item(stli_pkg::OP_QUERY, 32'sh7FFF_FFFF, 0);
		send_item(stli_pkg::OP_QUERY, 32'sh0002_0000, 0);
		send_item(stli_pkg::OP_QUERY, 32'sh0001_0000, 0);
		send_item(stli_pkg::OP_QUERY, -32'sh0000_0001, 0);
		send_item(stli_pkg::OP_QUERY, 32'sh7FFF_FFFE, 0);
		send_item(OP_SPARE, 32'sh1234_5678, 32'sh7654_3210);
		send_item(stli_pkg::OP_CLEAR, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
		send_item(stli_pkg::OP_QUERY, 0, 0);
		drain_and_settle();
	endtask

	task automatic test_full_table();
		for (int k = 0; k < stli_pkg::TABLE_DEPTH; k++)
			send_item(stli_pkg::OP_LOAD, (k * 32'sh0001_0000) - 32'sh0080_0000, $urandom);
		send_item(stli_pkg::OP_LOAD, 32'sh7000_0000, 1);
		send_item(stli_pkg::OP_QUERY, 32'sh0000_8000, 0);
		send_item(stli_pkg::OP_CLEAR, 0, 0);
		drain_and_settle();
	endtask

	task automatic test_log_mode();
		write_register(stli_pkg::CFG_LOG, 1'b1);
		send_item(stli_pkg::OP_LOAD, 0, -32'sh000A_0000);
		send_item(stli_pkg::OP_LOAD, 32'sh0014_0000, 32'sh000A_0000);
		send_item(stli_pkg::OP_LOAD, 32'sh0028_0000, 32'sh0000_0000);
		for (int k = 0; k < 12; k++)
			send_item(stli_pkg::OP_QUERY, $urandom_range(0, 32'h2A_0000), 0);
		send_item(stli_pkg::OP_QUERY, 32'sh0014_0000, 0);
		send_item(stli_pkg::OP_QUERY, -1, 0);
		drain_and_settle();
		write_register(stli_pkg::CFG_CLAMP, 1'b0);
		send_item(stli_pkg::OP_QUERY, -1, 0);
		send_item(stli_pkg::OP_QUERY, 32'sh0010_0000, 0);
		send_item(stli_pkg::OP_CLEAR, 0, 0);
		drain_and_settle();
	endtask

	// Random items: mostly small tables built then queried, some noise
	task automatic test_random(input int items);
		int sent, span;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 3) == 0) begin
				write_register(stli_pkg::CFG_CLAMP, $urandom_range(0, 1));
				write_register(stli_pkg::CFG_LOG, $urandom_range(0, 4) == 0);
			end
			span = $urandom_range(0, 1) ? 32'h0010_0000 : 32'h7FFF_FFFF;
			send_item(stli_pkg::OP_CLEAR, $urandom, $urandom);
			sent++;
			repeat ($urandom_range(0, 12)) begin
				send_item($urandom_range(0, 5) == 0 ? OP_SPARE : stli_pkg::OP_LOAD,
					$urandom_range(0, 1) ? int'($urandom) :
					int'($urandom_range(0, span)) - int'(span / 2),
					log_on ? int'($urandom_range(0, 32'h0018_0000)) - 32'sh000C_0000
					: int'($urandom));
				sent++;
			end
			repeat ($urandom_range(1, 20)) begin
				send_item(stli_pkg::OP_QUERY, $urandom_range(0, 1) ? int'($urandom) :
					int'($urandom_range(0, span)) - int'(span / 2), $urandom);
				sent++;
			end
			drain_and_settle();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_log_mode();
		write_register(stli_pkg::CFG_CLAMP, 1'b1);
		write_register(stli_pkg::CFG_LOG, 1'b0);
		test_random(720);
		drain_and_settle();
		if (error_count == 0) begin
			$display("tb_sorted_table_linear_interpolator OK");
		end else begin
			$display("tb_sorted_table_linear_interpolator NOT OK");
		end
		$finish;
	end
endmodule
